// ----- hdl/vlrp_pkg.sv -----
// Shared types and constants of the value log record parser.
`timescale 1ns / 1ps

package vlrp_pkg;

    // Width of the running buffer position
    localparam int OFFSET_BITS = 32;
    localparam int LEN_W       = 32;
    localparam int M_TDATA_W   = 144;

    typedef logic [OFFSET_BITS-1:0] t_pos;

    // Varint limits
    localparam logic [2:0] VARINT_MAX_BYTES = 3'd5;

    // Parser phases
    localparam logic [2:0] PH_KEY_HDR  = 3'd0;
    localparam logic [2:0] PH_VAL_HDR  = 3'd1;
    localparam logic [2:0] PH_KEY_DATA = 3'd2;
    localparam logic [2:0] PH_VAL_DATA = 3'd3;
    localparam logic [2:0] PH_SKIP     = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TRUNC    = 2'd1;
    localparam logic [1:0] ERR_OVERLONG = 2'd2;
    localparam logic [1:0] ERR_COUNT    = 2'd3;

    // Configuration register indexes
    localparam logic CFG_EXPECTED_ENTRIES = 1'b0;
    localparam logic CFG_CHECK_COUNT      = 1'b1;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic [1:0]       kind;
        logic             record_end;
        logic [LEN_W-1:0] key_length;
        logic [LEN_W-1:0] value_length;
        logic [31:0]      record_offset;
        logic [31:0]      record_index;
        logic [1:0]       error_code;
        logic             buffer_done;
    } t_result;

endpackage

// ----- hdl/vlrp_parse_core.sv -----
// Record parser state and single-step update logic for one buffer byte.
`timescale 1ns / 1ps

module vlrp_parse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_buffer,
    input  logic [31:0]       i_expected_entries,
    input  logic              i_check_count,
    output logic              o_have,
    output vlrp_pkg::t_result o_result
);

    logic [2:0]                     r_phase, n_phase;
    logic [31:0]                    r_acc, n_acc;
    logic [2:0]                     r_cnt, n_cnt;
    logic [vlrp_pkg::LEN_W-1:0]     r_klen, n_klen;
    logic [vlrp_pkg::LEN_W-1:0]     r_vlen, n_vlen;
    logic [31:0]                    r_rem, n_rem;
    vlrp_pkg::t_pos                 r_pos, n_pos;
    vlrp_pkg::t_pos                 r_rstart, n_rstart;
    logic [31:0]                    r_counter, n_counter;
    logic [1:0]                     r_err, n_err;

    logic        w_start;
    logic [4:0]  w_sh;
    logic [31:0] w_shifted;
    logic [31:0] w_acc_or;
    logic [31:0] w_rem_dec;
    logic [31:0] w_offset;
    logic        w_complete;

    // Latch record start on the first header byte of a record
    assign w_start  = (r_phase == vlrp_pkg::PH_KEY_HDR) && (r_cnt == 3'd0);
    assign n_rstart = w_start ? r_pos : r_rstart;

    // Report the low 32 bits of the record start
    generate
        if (vlrp_pkg::OFFSET_BITS >= 32) begin : g_off_wide
            assign w_offset = n_rstart[31:0];
        end else begin : g_off_narrow
            assign w_offset = {{(32 - vlrp_pkg::OFFSET_BITS){1'b0}}, n_rstart};
        end
    endgenerate

    // Select the 7-bit group position within the varint
    always_comb begin
        case (r_cnt)
            3'd0:    w_sh = 5'd0;
            3'd1:    w_sh = 5'd7;
            3'd2:    w_sh = 5'd14;
            3'd3:    w_sh = 5'd21;
            3'd4:    w_sh = 5'd28;
            3'd5:    w_sh = 5'd0;
            3'd6:    w_sh = 5'd7;
            default: w_sh = 5'd14;
        endcase
    end

    assign w_shifted = {25'd0, i_data_byte[6:0]} << w_sh;
    assign w_acc_or  = r_acc | w_shifted;
    assign w_rem_dec = r_rem - 32'd1;

    // Advance the parser by one byte and form the result
    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_klen     = w_start ? '0 : r_klen;
        n_vlen     = w_start ? '0 : r_vlen;
        n_rem      = r_rem;
        n_pos      = r_pos + vlrp_pkg::t_pos'(1);
        n_counter  = r_counter;
        n_err      = r_err;
        w_complete = 1'b0;
        o_have     = 1'b0;
        o_result   = '0;
        o_result.kind = vlrp_pkg::KIND_STATUS;

        case (r_phase)
            vlrp_pkg::PH_KEY_HDR, vlrp_pkg::PH_VAL_HDR: begin
                n_acc = w_acc_or;
                if (i_data_byte[7]) begin
                    n_cnt = r_cnt + 3'd1;
                    if (n_cnt >= vlrp_pkg::VARINT_MAX_BYTES) begin
                        n_err         = vlrp_pkg::ERR_OVERLONG;
                        n_phase       = vlrp_pkg::PH_SKIP;
                        o_have        = 1'b1;
                        o_result.kind = vlrp_pkg::KIND_STATUS;
                    end
                end else begin
                    n_acc = '0;
                    n_cnt = 3'd0;
                    if (r_phase == vlrp_pkg::PH_KEY_HDR) begin
                        n_klen  = w_acc_or;
                        n_phase = vlrp_pkg::PH_VAL_HDR;
                    end else begin
                        n_vlen = w_acc_or;
                        if (n_klen != '0) begin
                            n_phase = vlrp_pkg::PH_KEY_DATA;
                            n_rem   = n_klen;
                        end else if (w_acc_or != 32'd0) begin
                            n_phase = vlrp_pkg::PH_VAL_DATA;
                            n_rem   = w_acc_or;
                        end else begin
                            o_have              = 1'b1;
                            o_result.kind       = vlrp_pkg::KIND_EMPTY;
                            o_result.record_end = 1'b1;
                            w_complete          = 1'b1;
                        end
                    end
                end
            end
            vlrp_pkg::PH_KEY_DATA: begin
                o_have                = 1'b1;
                o_result.kind         = vlrp_pkg::KIND_KEY;
                o_result.payload_byte = i_data_byte;
                n_rem                 = w_rem_dec;
                if (w_rem_dec == 32'd0) begin
                    if (r_vlen != '0) begin
                        n_phase = vlrp_pkg::PH_VAL_DATA;
                        n_rem   = r_vlen;
                    end else begin
                        o_result.record_end = 1'b1;
                        w_complete          = 1'b1;
                    end
                end
            end
            vlrp_pkg::PH_VAL_DATA: begin
                o_have                = 1'b1;
                o_result.kind         = vlrp_pkg::KIND_VALUE;
                o_result.payload_byte = i_data_byte;
                n_rem                 = w_rem_dec;
                if (w_rem_dec == 32'd0) begin
                    o_result.record_end = 1'b1;
                    w_complete          = 1'b1;
                end
            end
            default: begin
                // skip phase: drop bytes until buffer end
            end
        endcase

        // Close a finished record
        if (w_complete) begin
            n_counter = r_counter + 32'd1;
            n_phase   = vlrp_pkg::PH_KEY_HDR;
        end

        // Final checks on the end-of-buffer byte
        if (i_end_of_buffer) begin
            if (n_err == vlrp_pkg::ERR_NONE &&
                !(n_phase == vlrp_pkg::PH_KEY_HDR && n_cnt == 3'd0))
                n_err = vlrp_pkg::ERR_TRUNC;
            if (n_err == vlrp_pkg::ERR_NONE && i_check_count &&
                n_counter != i_expected_entries)
                n_err = vlrp_pkg::ERR_COUNT;
            if (!o_have) begin
                o_have                = 1'b1;
                o_result.kind         = vlrp_pkg::KIND_STATUS;
                o_result.payload_byte = 8'd0;
                o_result.record_end   = 1'b0;
            end
        end

        o_result.key_length    = n_klen;
        o_result.value_length  = n_vlen;
        o_result.record_offset = w_offset;
        o_result.record_index  = r_counter;
        o_result.error_code    = n_err;
        o_result.buffer_done   = i_end_of_buffer;

        // Clear per-buffer state after the end byte
        if (i_end_of_buffer) begin
            n_phase   = vlrp_pkg::PH_KEY_HDR;
            n_acc     = '0;
            n_cnt     = 3'd0;
            n_rem     = '0;
            n_pos     = '0;
            n_counter = '0;
            n_err     = vlrp_pkg::ERR_NONE;
        end
    end

    // Commit state on each processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= vlrp_pkg::PH_KEY_HDR;
            r_acc     <= '0;
            r_cnt     <= 3'd0;
            r_klen    <= '0;
            r_vlen    <= '0;
            r_rem     <= '0;
            r_pos     <= '0;
            r_rstart  <= '0;
            r_counter <= '0;
            r_err     <= vlrp_pkg::ERR_NONE;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_klen    <= n_klen;
            r_vlen    <= n_vlen;
            r_rem     <= n_rem;
            r_pos     <= n_pos;
            r_rstart  <= n_rstart;
            r_counter <= n_counter;
            r_err     <= n_err;
        end
    end

endmodule

// ----- hdl/vlrp_out_reg.sv -----
// Output result register of the record parser.
`timescale 1ns / 1ps

module vlrp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  vlrp_pkg::t_result i_result,
    input  logic              i_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output vlrp_pkg::t_result o_result
);

    logic              r_valid;
    vlrp_pkg::t_result r_result;

    // Slot frees when empty or when the held request is taken
    assign o_can_load = !r_valid || i_ready;

    // Hold valid until the request is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Load payload on a new result
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hdl/value_log_record_parser_unit.sv -----
// Path: an accepted byte waits in the input register; its result is loaded into the result register.
// Throughput: one byte per cycle while results can be loaded; most header bytes give no result.
// The rate is set by the combinational parser step between the two registers.
// Reset: synchronous, active low; clears parser state, configuration and valid flags.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps

module value_log_record_parser_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_wr_en,
    input  logic                             i_cfg_index,
    input  logic [31:0]                      i_cfg_wdata,
    // input bytes
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [7:0]                       i_s_axis_tdata,  // [7:0] data_byte
    input  logic                             i_s_axis_tlast,  // end_of_buffer
    // results
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] payload_byte, [8] record_end, [40:9] key_length, [72:41] value_length,
    // [104:73] record_offset, [136:105] record_index, [138:137] error_code, rest 0
    output logic [vlrp_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic [1:0]                       o_m_axis_tuser,  // [1:0] kind
    output logic                             o_m_axis_tlast   // buffer_done
);

    logic [31:0]       r_expected_entries;
    logic              r_check_count;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;

    logic              w_step;
    logic              w_have;
    logic              w_can_load;
    vlrp_pkg::t_result w_result;
    vlrp_pkg::t_result w_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_entries <= '0;
            r_check_count      <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                vlrp_pkg::CFG_EXPECTED_ENTRIES: r_expected_entries <= i_cfg_wdata;
                vlrp_pkg::CFG_CHECK_COUNT:      r_check_count      <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Advance the held byte when its result has room or it gives none
    assign w_step          = r_in_valid && (!w_have || w_can_load);
    assign o_s_axis_tready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    vlrp_parse_core u_core (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (w_step),
        .i_data_byte        (r_in_byte),
        .i_end_of_buffer    (r_in_last),
        .i_expected_entries (r_expected_entries),
        .i_check_count      (r_check_count),
        .o_have             (w_have),
        .o_result           (w_result)
    );

    vlrp_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_step && w_have),
        .i_result   (w_result),
        .i_ready    (i_m_axis_tready),
        .o_can_load (w_can_load),
        .o_valid    (o_m_axis_tvalid),
        .o_result   (w_out)
    );

    // Pack result fields onto the stream
    assign o_m_axis_tdata = {5'd0, w_out.error_code, w_out.record_index, w_out.record_offset,
                             w_out.value_length, w_out.key_length, w_out.record_end,
                             w_out.payload_byte};
    assign o_m_axis_tuser = w_out.kind;
    assign o_m_axis_tlast = w_out.buffer_done;

    // Status results never close a record
    a_status_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == vlrp_pkg::KIND_STATUS) |-> !o_m_axis_tdata[8])
        else $error("status result marked as record end");

    // Empty marker closes a record with both lengths zero
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == vlrp_pkg::KIND_EMPTY) |->
        (o_m_axis_tdata[8] && w_out.key_length == '0 && w_out.value_length == '0))
        else $error("empty record marker with nonzero length or no record end");

    // Truncation and count errors appear only at buffer end
    a_end_errors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_out.error_code == vlrp_pkg::ERR_TRUNC ||
                             w_out.error_code == vlrp_pkg::ERR_COUNT)) |-> o_m_axis_tlast)
        else $error("end-of-buffer error reported before buffer end");

    // Only key and value results carry payload
    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != vlrp_pkg::KIND_KEY &&
         o_m_axis_tuser != vlrp_pkg::KIND_VALUE) |-> (o_m_axis_tdata[7:0] == 8'd0))
        else $error("nonzero payload on marker or status result");

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for the value log record parser: byte stream in, parsed results checked.
`timescale 1ns / 1ps

module tb;

    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 120;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pause;
    } t_log_item;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = '0;

    logic       src_valid = 1'b0;
    logic [7:0] src_data  = '0;
    logic       src_last  = 1'b0;
    logic       src_ready;

    logic                           sink_ready = 1'b0;
    logic                           res_valid;
    logic [vlrp_pkg::M_TDATA_W-1:0] res_data;
    logic [1:0]                     res_kind;
    logic                           res_last;

    // Pending log bytes, parser results still owed by the block, buffer under construction
    t_log_item          log_bytes_q [$];
    vlrp_pkg::t_result  due_results [$];
    logic [7:0]         frame [$];

    // Predictor copy of the parser and its configuration
    logic [2:0]     cur_phase = vlrp_pkg::PH_KEY_HDR;
    logic [31:0]    vint_acc = '0;
    int             vint_cnt = 0;
    logic [31:0]    key_len = '0;
    logic [31:0]    val_len = '0;
    logic [31:0]    bytes_left = '0;
    vlrp_pkg::t_pos buf_pos = '0;
    vlrp_pkg::t_pos rec_first = '0;
    logic [31:0]    recs_done = '0;
    logic [1:0]     held_err = vlrp_pkg::ERR_NONE;
    logic [31:0]    want_entries = '0;
    logic           count_check_on = 1'b0;

    // Run control and bookkeeping
    logic idle_on = 1'b1;
    logic pause_next = 1'b0;
    int   send_gap = 0;
    int   hold_requests = 0;
    int   hold_served = 0;
    int   stall_left = 0;
    int   queued_bytes = 0;
    int   bytes_in = 0;
    int   results_checked = 0;
    int   records_closed = 0;
    int   failures = 0;
    int   end_codes [4] = '{0, 0, 0, 0};

    value_log_record_parser_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (src_ready),
        .i_s_axis_tdata  (src_data),   // [7:0] data_byte
        .i_s_axis_tlast  (src_last),   // end_of_buffer
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (sink_ready),
        .o_m_axis_tdata  (res_data),   // [7:0] payload, [8] record_end, lengths, offset, index, error
        .o_m_axis_tuser  (res_kind),   // [1:0] kind
        .o_m_axis_tlast  (res_last)    // buffer_done
    );

    always #2 clk = ~clk;

    // Advance the parser by one accepted byte and queue the result it owes, if any
    task automatic parse_log_byte(input logic [7:0] b, input logic eob);
        vlrp_pkg::t_result r;
        logic [63:0]       wide;
        logic [31:0]       v;
        logic              have;
        logic              rec_done;
        r = '0;
        r.kind = vlrp_pkg::KIND_STATUS;
        have = 1'b0;
        rec_done = 1'b0;
        if (cur_phase == vlrp_pkg::PH_KEY_HDR && vint_cnt == 0) begin
            rec_first = buf_pos;
            key_len = '0;
            val_len = '0;
        end
        buf_pos = buf_pos + vlrp_pkg::t_pos'(1);
        r.record_index = recs_done;

        if (cur_phase == vlrp_pkg::PH_KEY_HDR || cur_phase == vlrp_pkg::PH_VAL_HDR) begin
            wide = {57'd0, b[6:0]} << (7 * (vint_cnt % 5));
            vint_acc = vint_acc | wide[31:0];
            if (b[7]) begin
                vint_cnt++;
                if (vint_cnt >= int'(vlrp_pkg::VARINT_MAX_BYTES)) begin
                    held_err = vlrp_pkg::ERR_OVERLONG;
                    cur_phase = vlrp_pkg::PH_SKIP;
                    have = 1'b1;
                end
            end else begin
                v = vint_acc;
                vint_acc = '0;
                vint_cnt = 0;
                if (cur_phase == vlrp_pkg::PH_KEY_HDR) begin
                    key_len = v;
                    cur_phase = vlrp_pkg::PH_VAL_HDR;
                end else begin
                    val_len = v;
                    if (key_len != 0) begin
                        cur_phase = vlrp_pkg::PH_KEY_DATA;
                        bytes_left = key_len;
                    end else if (val_len != 0) begin
                        cur_phase = vlrp_pkg::PH_VAL_DATA;
                        bytes_left = val_len;
                    end else begin
                        have = 1'b1;
                        r.kind = vlrp_pkg::KIND_EMPTY;
                        rec_done = 1'b1;
                    end
                end
            end
        end else if (cur_phase == vlrp_pkg::PH_KEY_DATA) begin
            have = 1'b1;
            r.kind = vlrp_pkg::KIND_KEY;
            r.payload_byte = b;
            bytes_left = bytes_left - 32'd1;
            if (bytes_left == 0) begin
                if (val_len != 0) begin
                    cur_phase = vlrp_pkg::PH_VAL_DATA;
                    bytes_left = val_len;
                end else begin
                    rec_done = 1'b1;
                end
            end
        end else if (cur_phase == vlrp_pkg::PH_VAL_DATA) begin
            have = 1'b1;
            r.kind = vlrp_pkg::KIND_VALUE;
            r.payload_byte = b;
            bytes_left = bytes_left - 32'd1;
            if (bytes_left == 0)
                rec_done = 1'b1;
        end

        if (rec_done) begin
            recs_done = recs_done + 32'd1;
            cur_phase = vlrp_pkg::PH_KEY_HDR;
            r.record_end = 1'b1;
        end

        // Buffer end: settle the error and always report
        if (eob) begin
            if (held_err == vlrp_pkg::ERR_NONE &&
                !(cur_phase == vlrp_pkg::PH_KEY_HDR && vint_cnt == 0))
                held_err = vlrp_pkg::ERR_TRUNC;
            if (held_err == vlrp_pkg::ERR_NONE && count_check_on && recs_done != want_entries)
                held_err = vlrp_pkg::ERR_COUNT;
            have = 1'b1;
        end

        if (have) begin
            r.key_length = key_len;
            r.value_length = val_len;
            r.record_offset = rec_first[31:0];
            r.error_code = held_err;
            r.buffer_done = eob;
            due_results.push_back(r);
        end

        if (eob) begin
            cur_phase = vlrp_pkg::PH_KEY_HDR;
            vint_acc = '0;
            vint_cnt = 0;
            bytes_left = '0;
            buf_pos = '0;
            recs_done = '0;
            held_err = vlrp_pkg::ERR_NONE;
        end
    endtask

    // Sender: present queued bytes, with random gaps and pause points
    always @(posedge clk) begin : drive
        t_log_item nxt;
        logic      load;
        load = 1'b0;
        if (!rst_n) begin
            src_valid <= 1'b0;
        end else begin
            if (src_valid && src_ready) begin
                parse_log_byte(src_data, src_last);
                bytes_in++;
            end
            if (!src_valid || src_ready) begin
                if (log_bytes_q.size() != 0 && log_bytes_q[0].pause) begin
                    // hold until the block has delivered everything owed
                    if (due_results.size() == 0)
                        nxt = log_bytes_q.pop_front();
                end else if (send_gap > 0) begin
                    send_gap--;
                end else if (log_bytes_q.size() != 0) begin
                    if (idle_on && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(0, 3);
                    end else begin
                        nxt = log_bytes_q.pop_front();
                        load = 1'b1;
                    end
                end
                src_valid <= load;
                if (load) begin
                    src_data <= nxt.data;
                    src_last <= nxt.last;
                end
            end
        end
    end

    // Receiver: random short stalls, plus long hold-offs on request
    always @(posedge clk) begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
        end else begin
            if (hold_served != hold_requests) begin
                hold_served++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                sink_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 3);
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // Compare each delivered result with the oldest one owed
    always @(posedge clk) begin : watch
        vlrp_pkg::t_result want;
        if (rst_n && res_valid && sink_ready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result: tdata 0x%0h kind %0d last %0b",
                       res_data, res_kind, res_last);
                failures++;
            end else begin
                want = due_results.pop_front();
                check_field("payload_byte", 32'(want.payload_byte), 32'(res_data[7:0]));
                check_field("kind", 32'(want.kind), 32'(res_kind));
                check_field("record_end", 32'(want.record_end), 32'(res_data[8]));
                check_field("key_length", want.key_length, res_data[40:9]);
                check_field("value_length", want.value_length, res_data[72:41]);
                check_field("record_offset", want.record_offset, res_data[104:73]);
                check_field("record_index", want.record_index, res_data[136:105]);
                check_field("error_code", 32'(want.error_code), 32'(res_data[138:137]));
                check_field("buffer_done", 32'(want.buffer_done), 32'(res_last));
                check_field("tdata padding", '0,
                            32'(res_data[vlrp_pkg::M_TDATA_W-1:139]));
                results_checked++;
                if (want.record_end)
                    records_closed++;
                if (want.buffer_done)
                    end_codes[want.error_code]++;
            end
        end
    end

    task automatic push_log_byte(input logic [7:0] b, input logic last);
        log_bytes_q.push_back('{data: b, last: last, pause: 1'b0});
        queued_bytes++;
    endtask

    // Append a varint, sometimes padded with redundant zero groups
    task automatic add_varint(input logic [31:0] v);
        logic [31:0] rest;
        logic [7:0]  grp;
        int          n;
        int          total;
        n = 1;
        rest = v >> 7;
        while (rest != 0) begin
            n++;
            rest = rest >> 7;
        end
        total = n;
        if ($urandom_range(0, 3) == 0)
            total = n + $urandom_range(1, 4);
        if (total > 5)
            total = 5;
        for (int i = 0; i < total; i++) begin
            grp = 8'((v >> (7 * i)) & 32'h7F);
            // bits above 31 in a fifth group are dropped by the parser
            if (i == 4)
                grp[6:4] = 3'($urandom_range(0, 7));
            if (i < total - 1)
                grp[7] = 1'b1;
            frame.push_back(grp);
        end
    endtask

    function automatic logic [31:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 6);
        else if (r < 97)
            return $urandom_range(7, 40);
        return $urandom_range(41, 300);
    endfunction

    task automatic add_record(input logic [31:0] klen, input logic [31:0] vlen);
        add_varint(klen);
        add_varint(vlen);
        repeat (klen + vlen) frame.push_back(8'($urandom_range(0, 255)));
    endtask

    // Build one buffer of records, maybe broken, then queue it with its end mark
    task automatic build_buffer(input int nrec);
        int r;
        int cut;
        int mid;
        frame.delete();
        repeat (nrec) add_record(pick_len(), pick_len());
        r = $urandom_range(0, 99);
        if (r < 12 && frame.size() > 1) begin
            // end inside a record
            cut = $urandom_range(1, frame.size() - 1);
            while (frame.size() > cut)
                void'(frame.pop_back());
        end else if (r < 20) begin
            // overlong varint, then bytes the parser must skip
            if ($urandom_range(0, 1))
                add_varint($urandom_range(0, 5));
            repeat (5) frame.push_back(8'h80 | 8'($urandom_range(0, 127)));
            repeat ($urandom_range(0, 4)) frame.push_back(8'($urandom_range(0, 255)));
        end else if (r < 26) begin
            repeat ($urandom_range(1, 8)) frame.push_back(8'($urandom_range(0, 255)));
        end else if (r < 32) begin
            // huge length, cut after a few body bytes
            if ($urandom_range(0, 1)) begin
                add_varint($urandom());
                add_varint($urandom_range(0, 3));
            end else begin
                add_varint(0);
                add_varint($urandom());
            end
            repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
        end
        if (frame.size() == 0)
            frame.push_back(8'($urandom_range(0, 255)));

        mid = -1;
        if (pause_next || (idle_on && $urandom_range(0, 24) == 0))
            mid = frame.size() / 2;
        pause_next = 1'b0;
        foreach (frame[i]) begin
            if (i == mid)
                log_bytes_q.push_back('{data: 8'h00, last: 1'b0, pause: 1'b1});
            push_log_byte(frame[i], i == frame.size() - 1);
        end
    endtask

    // Wait until the block has taken and answered everything, then let it settle
    task automatic wait_idle();
        @(posedge clk);
        while (log_bytes_q.size() != 0 || src_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [31:0] entries, input logic chk);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= vlrp_pkg::CFG_EXPECTED_ENTRIES;
        cfg_wdata <= entries;
        want_entries = entries;
        @(posedge clk);
        cfg_index <= vlrp_pkg::CFG_CHECK_COUNT;
        cfg_wdata <= ($urandom() & 32'hFFFF_FFFE) | {31'd0, chk};
        count_check_on = chk;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] entries, input logic chk,
                             input int lo, input int hi, input logic long_hold);
        int goal;
        set_config(entries, chk);
        if (long_hold)
            hold_requests <= hold_requests + 1;
        // keep offering bytes through a long hold so the block fills up
        pause_next = idle_on && !long_hold;
        goal = queued_bytes + 300;
        while (queued_bytes < goal)
            build_buffer($urandom_range(lo, hi));
        wait_idle();
    endtask

    initial begin : stimulus
        logic [8:0] opening [$];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed buffers, {end mark, byte}: clean empty, key-only and value-only records,
        // overlong varint with skipped tail, cut in key data, cut in a header,
        // five-byte all-ones length with dropped upper bits
        opening = '{9'h000, 9'h000, 9'h001, 9'h000, 9'h0FF, 9'h000, 9'h001, 9'h180,
                    9'h080, 9'h080, 9'h080, 9'h080, 9'h080, 9'h012, 9'h134,
                    9'h003, 9'h000, 9'h055, 9'h1AA,
                    9'h185,
                    9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h000, 9'h1AB};
        foreach (opening[i])
            push_log_byte(opening[i][7:0], opening[i][8]);
        wait_idle();

        run_phase(32'd0, 1'b1, 1, 2, 1'b0);
        run_phase(32'd3, 1'b1, 2, 4, 1'b1);
        run_phase(32'hFFFF_FFFF, 1'b1, 1, 5, 1'b0);
        run_phase($urandom(), 1'b0, 0, 6, 1'b1);
        run_phase(32'd1, 1'b1, 0, 2, 1'b0);
        // closing stretch at full rate on both sides
        idle_on <= 1'b0;
        run_phase(32'd2, 1'b1, 1, 3, 1'b0);

        $display("Fed %0d bytes; checked %0d results covering %0d complete records.",
                 bytes_in, results_checked, records_closed);
        $display("Buffer endings: ok %0d, truncated %0d, overlong %0d, count mismatch %0d.",
                 end_codes[vlrp_pkg::ERR_NONE], end_codes[vlrp_pkg::ERR_TRUNC],
                 end_codes[vlrp_pkg::ERR_OVERLONG], end_codes[vlrp_pkg::ERR_COUNT]);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
